@@ hw/rtl/lri_pkg.sv @@
`default_nettype none

package lri_pkg;

    // Fixed field widths of the color word
    localparam int COLOR_W   = 32;
    localparam int CHAN_W    = 8;
    localparam int NUM_COLOR = 4;

    // Interpolated quantity selected for the shared divider
    typedef logic [2:0] chan_idx_t;
    localparam chan_idx_t CH_DEPTH = 3'd0;
    localparam chan_idx_t CH_RED   = 3'd1;
    localparam chan_idx_t CH_GREEN = 3'd2;
    localparam chan_idx_t CH_BLUE  = 3'd3;
    localparam chan_idx_t CH_ALPHA = 3'd4;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_LOAD   = 4'b0010,
        ST_DIVIDE = 4'b0100,
        ST_EMIT   = 4'b1000
    } state_t;

endpackage

`default_nettype wire

@@ hw/rtl/lri_divider.sv @@
`default_nettype none

// Restoring divider, one quotient bit per cycle; sign applied to the result.
module lri_divider #(
    parameter int NUM_W = 32,
    parameter int DEN_W = 6
) (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    start,
    input  wire logic                    neg,
    input  wire logic [NUM_W-1:0]        numer,
    input  wire logic [DEN_W-1:0]        denom,
    output logic                         done,
    output logic signed [NUM_W:0]        quotient
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [NUM_W-1:0] quo_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [DEN_W-1:0] den_reg;
    logic             neg_reg;

    logic [DEN_W:0]   part;
    logic [DEN_W:0]   part_diff;
    logic             part_ge;
    logic [NUM_W:0]   quo_ext;

    // One restoring step: shift in next numerator bit, try subtract
    always_comb begin
        part      = {rem_reg, quo_reg[NUM_W-1]};
        part_diff = part - {1'b0, den_reg};
        part_ge   = part >= {1'b0, den_reg};
    end

    // Control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(NUM_W);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= numer;
            rem_reg <= '0;
            den_reg <= denom;
            neg_reg <= neg;
        end else if (busy_reg) begin
            quo_reg <= {quo_reg[NUM_W-2:0], part_ge};
            rem_reg <= part_ge ? part_diff[DEN_W-1:0] : part[DEN_W-1:0];
        end
    end

    assign quo_ext  = {1'b0, quo_reg};
    assign quotient = neg_reg ? (~quo_ext + 1'b1) : quo_ext;
    assign done     = done_reg;

endmodule

`default_nettype wire

@@ hw/rtl/line_rasterizer_interpolated.sv @@
// Timing: after a segment is accepted, the sequencer runs a load state before each of five passes
// of the shared bit-serial divider (depth, red, green, blue, alpha), then emits the first pixel.
// Throughput: then |major delta| + 1 pixels at one per cycle while m_tready is high; a
// single-point segment skips the divider and goes from the load state straight to emit.
// s_tready returns the cycle after the last pixel is taken.
// Reset: aresetn is synchronous, active low; it clears the sequencer to idle.
`default_nettype none

module line_rasterizer_interpolated
    import lri_pkg::*;
#(
    parameter int COORD_BITS = 6,
    parameter int DEPTH_BITS = 16,
    parameter int FRAC_BITS  = 16
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    // x_start, y_start, depth_start, color_start, x_end, y_end, depth_end, color_end
    input  wire logic [((2*(2*COORD_BITS+DEPTH_BITS+32)+7)/8)*8-1:0] s_tdata,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    // pixel_x, pixel_y, pixel_depth, red, green, blue, alpha
    output logic [((2*COORD_BITS+DEPTH_BITS+32+7)/8)*8-1:0] m_tdata,
    output logic                      m_tlast
);

    localparam int C       = COORD_BITS;
    localparam int PT_W    = 2*C + DEPTH_BITS + COLOR_W;
    localparam int OUT_RAW = 2*C + DEPTH_BITS + NUM_COLOR*CHAN_W;
    localparam int OUT_W   = ((OUT_RAW + 7) / 8) * 8;
    localparam int NUM_W   = DEPTH_BITS + FRAC_BITS;
    localparam int CACC_W  = CHAN_W + FRAC_BITS;
    localparam int ERR_W   = C + 3;

    state_t    state_reg;
    chan_idx_t ch_reg;

    // Unpacked endpoints
    logic [C-1:0]          xa, ya, xb, yb;
    logic [DEPTH_BITS-1:0] za, zb;
    logic [COLOR_W-1:0]    ca, cb;

    // Segment setup
    logic [C-1:0]          adx, ady, sx, sy, ex, ey;
    logic [C-1:0]          major0, minor0, minor_end, nmaj0, nmin0;
    logic [DEPTH_BITS-1:0] zs0, ze0;
    logic [COLOR_W-1:0]    cs0, ce0;
    logic                  xmaj0, swap0;

    // Walk registers
    logic                  xmaj_reg, dir_up_reg;
    logic [C-1:0]          nmaj_reg, nmin_reg, major_reg, minor_reg;
    logic signed [ERR_W-1:0] err_reg;
    logic [C:0]            left_reg;
    logic [DEPTH_BITS-1:0] zs_reg, ze_reg;
    logic [COLOR_W-1:0]    cs_reg, ce_reg;
    logic [NUM_W-1:0]      dacc_reg;
    logic signed [NUM_W:0] dstep_reg;
    logic [CACC_W-1:0]     cacc_reg  [NUM_COLOR];
    logic signed [CACC_W:0] cstep_reg [NUM_COLOR];

    // Walk step
    logic signed [ERR_W-1:0] err_add, nmin2, nmaj2, nmaj_ext;
    logic                    minor_step, last_pix;

    // Divider interface
    logic                  div_start, div_neg, div_done;
    logic [DEPTH_BITS-1:0] op_from, op_to, op_mag;
    logic signed [NUM_W:0] div_q;

    logic                  in_acc, out_acc;
    logic [C-1:0]          px, py;
    logic [CHAN_W-1:0]     chan_out [NUM_COLOR];

    assign in_acc  = s_tvalid && s_tready;
    assign out_acc = m_tvalid && m_tready;

    // Input unpacking
    assign xa = s_tdata[C-1:0];
    assign ya = s_tdata[2*C-1:C];
    assign za = s_tdata[2*C+DEPTH_BITS-1:2*C];
    assign ca = s_tdata[PT_W-1:2*C+DEPTH_BITS];
    assign xb = s_tdata[PT_W+C-1:PT_W];
    assign yb = s_tdata[PT_W+2*C-1:PT_W+C];
    assign zb = s_tdata[PT_W+2*C+DEPTH_BITS-1:PT_W+2*C];
    assign cb = s_tdata[2*PT_W-1:PT_W+2*C+DEPTH_BITS];

    // Axis choice and endpoint ordering
    always_comb begin
        adx   = (xb >= xa) ? (xb - xa) : (xa - xb);
        ady   = (yb >= ya) ? (yb - ya) : (ya - yb);
        xmaj0 = ady < adx;
        swap0 = xmaj0 ? (xa > xb) : (ya > yb);
        sx  = swap0 ? xb : xa;
        sy  = swap0 ? yb : ya;
        zs0 = swap0 ? zb : za;
        cs0 = swap0 ? cb : ca;
        ex  = swap0 ? xa : xb;
        ey  = swap0 ? ya : yb;
        ze0 = swap0 ? za : zb;
        ce0 = swap0 ? ca : cb;
        major0    = xmaj0 ? sx : sy;
        minor0    = xmaj0 ? sy : sx;
        minor_end = xmaj0 ? ey : ex;
        nmaj0     = xmaj0 ? adx : ady;
        nmin0     = xmaj0 ? ady : adx;
    end

    // Error term update for the next pixel
    always_comb begin
        nmin2      = ERR_W'({nmin_reg, 1'b0});
        nmaj2      = ERR_W'({nmaj_reg, 1'b0});
        nmaj_ext   = ERR_W'(nmaj_reg);
        err_add    = err_reg + nmin2;
        minor_step = err_add >= nmaj_ext;
        last_pix   = left_reg == (C+1)'(1);
    end

    // Divider operand selection
    always_comb begin
        case (ch_reg)
            CH_RED: begin
                op_from = DEPTH_BITS'(cs_reg[COLOR_W-1 -: CHAN_W]);
                op_to   = DEPTH_BITS'(ce_reg[COLOR_W-1 -: CHAN_W]);
            end
            CH_GREEN: begin
                op_from = DEPTH_BITS'(cs_reg[COLOR_W-1-CHAN_W -: CHAN_W]);
                op_to   = DEPTH_BITS'(ce_reg[COLOR_W-1-CHAN_W -: CHAN_W]);
            end
            CH_BLUE: begin
                op_from = DEPTH_BITS'(cs_reg[COLOR_W-1-2*CHAN_W -: CHAN_W]);
                op_to   = DEPTH_BITS'(ce_reg[COLOR_W-1-2*CHAN_W -: CHAN_W]);
            end
            CH_ALPHA: begin
                op_from = DEPTH_BITS'(cs_reg[CHAN_W-1:0]);
                op_to   = DEPTH_BITS'(ce_reg[CHAN_W-1:0]);
            end
            default: begin
                op_from = zs_reg;
                op_to   = ze_reg;
            end
        endcase
        div_neg = op_to < op_from;
        op_mag  = div_neg ? (op_from - op_to) : (op_to - op_from);
    end

    assign div_start = (state_reg == ST_LOAD) && (nmaj_reg != '0);

    lri_divider #(
        .NUM_W (NUM_W),
        .DEN_W (C)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .neg      (div_neg),
        .numer    ({op_mag, {FRAC_BITS{1'b0}}}),
        .denom    (nmaj_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    // Sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            ch_reg    <= CH_DEPTH;
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    if (in_acc) begin
                        state_reg <= ST_LOAD;
                        ch_reg    <= CH_DEPTH;
                    end
                end
                ST_LOAD: begin
                    state_reg <= (nmaj_reg == '0) ? ST_EMIT : ST_DIVIDE;
                end
                ST_DIVIDE: begin
                    if (div_done) begin
                        if (ch_reg == CH_ALPHA) begin
                            state_reg <= ST_EMIT;
                        end else begin
                            state_reg <= ST_LOAD;
                            ch_reg    <= ch_reg + 1'b1;
                        end
                    end
                end
                ST_EMIT: begin
                    if (out_acc && last_pix) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Segment load and pixel walk
    always_ff @(posedge aclk) begin
        if (in_acc) begin
            xmaj_reg   <= xmaj0;
            dir_up_reg <= minor_end > minor0;
            nmaj_reg   <= nmaj0;
            nmin_reg   <= nmin0;
            major_reg  <= major0;
            minor_reg  <= minor0;
            err_reg    <= '0;
            left_reg   <= {1'b0, nmaj0} + 1'b1;
            zs_reg     <= zs0;
            ze_reg     <= ze0;
            cs_reg     <= cs0;
            ce_reg     <= ce0;
            dacc_reg   <= {zs0, {FRAC_BITS{1'b0}}};
            for (int k = 0; k < NUM_COLOR; k++) begin
                cacc_reg[k] <= {cs0[COLOR_W-1-CHAN_W*k -: CHAN_W], {FRAC_BITS{1'b0}}};
            end
        end else if (out_acc && !last_pix) begin
            left_reg  <= left_reg - 1'b1;
            major_reg <= major_reg + 1'b1;
            if (minor_step) begin
                minor_reg <= dir_up_reg ? (minor_reg + 1'b1) : (minor_reg - 1'b1);
                err_reg   <= err_add - nmaj2;
            end else begin
                err_reg <= err_add;
            end
            dacc_reg <= dacc_reg + dstep_reg[NUM_W-1:0];
            for (int k = 0; k < NUM_COLOR; k++) begin
                cacc_reg[k] <= cacc_reg[k] + cstep_reg[k][CACC_W-1:0];
            end
        end
    end

    // Increment capture from the divider
    always_ff @(posedge aclk) begin
        if ((state_reg == ST_DIVIDE) && div_done) begin
            case (ch_reg)
                CH_RED:   cstep_reg[0] <= div_q[CACC_W:0];
                CH_GREEN: cstep_reg[1] <= div_q[CACC_W:0];
                CH_BLUE:  cstep_reg[2] <= div_q[CACC_W:0];
                CH_ALPHA: cstep_reg[3] <= div_q[CACC_W:0];
                default:  dstep_reg    <= div_q;
            endcase
        end
    end

    // Output packing
    always_comb begin
        px = xmaj_reg ? major_reg : minor_reg;
        py = xmaj_reg ? minor_reg : major_reg;
        for (int k = 0; k < NUM_COLOR; k++) begin
            chan_out[k] = cacc_reg[k][CACC_W-1:FRAC_BITS];
        end
    end

    assign s_tready = state_reg == ST_IDLE;
    assign m_tvalid = state_reg == ST_EMIT;
    assign m_tlast  = last_pix;
    assign m_tdata  = OUT_W'({chan_out[3], chan_out[2], chan_out[1], chan_out[0],
                              dacc_reg[NUM_W-1:FRAC_BITS], py, px});

endmodule

`default_nettype wire

@@ tb/sv/lri_pixel_checker.sv @@
`default_nettype none

module lri_pixel_checker
    import lri_pkg::*;
#(
    parameter int COORD_BITS = 6,
    parameter int DEPTH_BITS = 16,
    parameter int FRAC_BITS  = 16
) (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic s_tvalid,
    input  wire logic s_tready,
    input  wire logic [((2*(2*COORD_BITS+DEPTH_BITS+COLOR_W)+7)/8)*8-1:0] s_tdata,
    input  wire logic m_tvalid,
    input  wire logic m_tready,
    input  wire logic [((2*COORD_BITS+DEPTH_BITS+COLOR_W+7)/8)*8-1:0] m_tdata,
    input  wire logic m_tlast,
    output int        pixels_pending,
    output int        mismatches
);

    localparam int S_W      = ((2*(2*COORD_BITS+DEPTH_BITS+COLOR_W)+7)/8)*8;
    localparam int END_OFF  = 2*COORD_BITS + DEPTH_BITS + COLOR_W;
    localparam int Z_OFF    = 2*COORD_BITS;
    localparam int C_OFF    = 2*COORD_BITS + DEPTH_BITS;
    localparam int POS_MASK = (1 << COORD_BITS) - 1;

    typedef struct packed {
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
        logic [DEPTH_BITS-1:0] depth;
        logic [CHAN_W-1:0]     red;
        logic [CHAN_W-1:0]     green;
        logic [CHAN_W-1:0]     blue;
        logic [CHAN_W-1:0]     alpha;
        logic                  last;
    } pixel_t;

    pixel_t expected_pixels[$];

    // per-step increment in fixed point, truncated toward zero
    function automatic longint slope_of(input longint from, input longint to, input int span);
        if (span == 0)
            return 0;
        return ((to - from) * (longint'(1) << FRAC_BITS)) / longint'(span);
    endfunction

    // integer part of an accumulator, with negative values clamped to zero
    function automatic longint floor_of(input longint acc);
        return (acc < 0) ? longint'(0) : (acc >>> FRAC_BITS);
    endfunction

    // walk one segment and queue every pixel it should produce
    function automatic void rasterize_segment(input logic [S_W-1:0] seg);
        int ax, ay, bx, by, sx, sy, ex, ey;
        longint az, bz, zs, ze;
        logic [COLOR_W-1:0] ac, bc, cs, ce;
        int adx, ady, span, minor_span, maj, mnr, mnr_end, dir, err, left;
        bit x_major;
        longint z_acc, z_inc;
        longint c_acc[NUM_COLOR];
        longint c_inc[NUM_COLOR];
        longint c_from, c_to;
        pixel_t pix;

        ax = int'(seg[0 +: COORD_BITS]);
        ay = int'(seg[COORD_BITS +: COORD_BITS]);
        az = longint'(seg[Z_OFF +: DEPTH_BITS]);
        ac = seg[C_OFF +: COLOR_W];
        bx = int'(seg[END_OFF +: COORD_BITS]);
        by = int'(seg[END_OFF + COORD_BITS +: COORD_BITS]);
        bz = longint'(seg[END_OFF + Z_OFF +: DEPTH_BITS]);
        bc = seg[END_OFF + C_OFF +: COLOR_W];

        adx = (bx > ax) ? bx - ax : ax - bx;
        ady = (by > ay) ? by - ay : ay - by;
        x_major = ady < adx;

        // always walk from the smaller major coordinate
        if (x_major ? (ax > bx) : (ay > by)) begin
            sx = bx; sy = by; zs = bz; cs = bc;
            ex = ax; ey = ay; ze = az; ce = ac;
        end else begin
            sx = ax; sy = ay; zs = az; cs = ac;
            ex = bx; ey = by; ze = bz; ce = bc;
        end

        if (x_major) begin
            maj = sx; mnr = sy; mnr_end = ey; span = adx; minor_span = ady;
        end else begin
            maj = sy; mnr = sx; mnr_end = ex; span = ady; minor_span = adx;
        end
        dir = (mnr_end > mnr) ? 1 : -1;

        err   = 0;
        left  = span + 1;
        z_acc = zs * (longint'(1) << FRAC_BITS);
        z_inc = slope_of(zs, ze, span);
        for (int k = 0; k < NUM_COLOR; k++) begin
            c_from   = longint'(cs[COLOR_W-1-CHAN_W*k -: CHAN_W]);
            c_to     = longint'(ce[COLOR_W-1-CHAN_W*k -: CHAN_W]);
            c_acc[k] = c_from * (longint'(1) << FRAC_BITS);
            c_inc[k] = slope_of(c_from, c_to, span);
        end

        while (left > 0) begin
            pix.x     = COORD_BITS'(x_major ? maj : mnr);
            pix.y     = COORD_BITS'(x_major ? mnr : maj);
            pix.depth = DEPTH_BITS'(floor_of(z_acc));
            pix.red   = CHAN_W'(floor_of(c_acc[0]));
            pix.green = CHAN_W'(floor_of(c_acc[1]));
            pix.blue  = CHAN_W'(floor_of(c_acc[2]));
            pix.alpha = CHAN_W'(floor_of(c_acc[3]));
            pix.last  = (left == 1);
            expected_pixels.push_back(pix);
            left--;

            // minor step once the error term reaches half a pixel
            err += 2 * minor_span;
            if (err >= span && left > 0) begin
                mnr = (mnr + dir) & POS_MASK;
                err -= 2 * span;
            end
            if (left > 0) begin
                maj = (maj + 1) & POS_MASK;
                z_acc += z_inc;
                for (int k = 0; k < NUM_COLOR; k++)
                    c_acc[k] += c_inc[k];
            end
        end
    endfunction

    initial begin
        pixels_pending = 0;
        mismatches     = 0;
    end

    // sample both channels at the rising edge
    always @(posedge aclk) begin
        pixel_t got, want;
        if (aresetn) begin
            if (s_tvalid && s_tready)
                rasterize_segment(s_tdata);

            if (m_tvalid && m_tready) begin
                got.x     = m_tdata[0 +: COORD_BITS];
                got.y     = m_tdata[COORD_BITS +: COORD_BITS];
                got.depth = m_tdata[Z_OFF +: DEPTH_BITS];
                got.red   = m_tdata[C_OFF +: CHAN_W];
                got.green = m_tdata[C_OFF + CHAN_W +: CHAN_W];
                got.blue  = m_tdata[C_OFF + 2*CHAN_W +: CHAN_W];
                got.alpha = m_tdata[C_OFF + 3*CHAN_W +: CHAN_W];
                got.last  = m_tlast;
                if (expected_pixels.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected pixel transaction: x=%0d y=%0d z=%0d rgba=%h last=%0d",
                                 got.x, got.y, got.depth,
                                 {got.red, got.green, got.blue, got.alpha}, got.last);
                end else begin
                    want = expected_pixels.pop_front();
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("pixel mismatch: exp x=%0d y=%0d z=%0d rgba=%h last=%0d",
                                     want.x, want.y, want.depth,
                                     {want.red, want.green, want.blue, want.alpha}, want.last);
                            $display("                got x=%0d y=%0d z=%0d rgba=%h last=%0d",
                                     got.x, got.y, got.depth,
                                     {got.red, got.green, got.blue, got.alpha}, got.last);
                        end
                    end
                end
            end
            pixels_pending = expected_pixels.size();
        end
    end

endmodule

`default_nettype wire

@@ tb/sv/tb_line_rasterizer_interpolated.sv @@
`default_nettype none

module tb_line_rasterizer_interpolated;
    import lri_pkg::*;

    localparam int COORD_BITS  = 6;
    localparam int DEPTH_BITS  = 16;
    localparam int FRAC_BITS   = 16;
    localparam int S_W         = ((2*(2*COORD_BITS+DEPTH_BITS+COLOR_W)+7)/8)*8;
    localparam int M_W         = ((2*COORD_BITS+DEPTH_BITS+COLOR_W+7)/8)*8;
    localparam int MAX_POS     = (1 << COORD_BITS) - 1;
    localparam int RANDOM_SEGS = 390;
    localparam int QUIET_TAIL  = 60;
    localparam int HOLD_AT     = 60;
    localparam int HOLD_CYCLES = 400;

    logic aclk = 1'b0;
    logic aresetn;
    logic s_tvalid;
    logic s_tready;
    // x_start, y_start, depth_start, color_start, x_end, y_end, depth_end, color_end
    logic [S_W-1:0] s_tdata;
    logic m_tvalid;
    logic m_tready;
    // pixel_x, pixel_y, pixel_depth, red, green, blue, alpha
    logic [M_W-1:0] m_tdata;
    logic m_tlast;

    int pixels_pending;
    int mismatches;
    int segs_sent = 0;
    bit rx_idling = 1'b1;

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    line_rasterizer_interpolated #(
        .COORD_BITS(COORD_BITS),
        .DEPTH_BITS(DEPTH_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tlast (m_tlast)
    );

    lri_pixel_checker #(
        .COORD_BITS(COORD_BITS),
        .DEPTH_BITS(DEPTH_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) i_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tlast       (m_tlast),
        .pixels_pending(pixels_pending),
        .mismatches    (mismatches)
    );

    // pack one segment, first field in the low bits
    function automatic logic [S_W-1:0] segment(
        input int xa, input int ya, input logic [DEPTH_BITS-1:0] za, input logic [COLOR_W-1:0] ca,
        input int xb, input int yb, input logic [DEPTH_BITS-1:0] zb, input logic [COLOR_W-1:0] cb);
        logic [COORD_BITS-1:0] xa_f, ya_f, xb_f, yb_f;
        xa_f = COORD_BITS'(xa);
        ya_f = COORD_BITS'(ya);
        xb_f = COORD_BITS'(xb);
        yb_f = COORD_BITS'(yb);
        return S_W'({cb, zb, yb_f, xb_f, ca, za, ya_f, xa_f});
    endfunction

    function automatic int clip(input int v);
        return (v < 0) ? 0 : ((v > MAX_POS) ? MAX_POS : v);
    endfunction

    function automatic logic [DEPTH_BITS-1:0] random_depth();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return DEPTH_BITS'($urandom);
        endcase
    endfunction

    function automatic logic [COLOR_W-1:0] random_color();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            default: return $urandom;
        endcase
    endfunction

    // random-endpoint and short segments, plus axis-aligned, diagonal and single-point ones
    function automatic logic [S_W-1:0] random_segment();
        int kind, xa, ya, xb, yb, d;
        kind = $urandom_range(0, 99);
        xa = $urandom_range(0, MAX_POS);
        ya = $urandom_range(0, MAX_POS);
        if (kind < 40) begin
            xb = $urandom_range(0, MAX_POS);
            yb = $urandom_range(0, MAX_POS);
        end else if (kind < 82) begin
            xb = clip(xa + $urandom_range(0, 16) - 8);
            yb = clip(ya + $urandom_range(0, 16) - 8);
        end else if (kind < 90) begin
            xb = $urandom_range(0, 1) ? xa : $urandom_range(0, MAX_POS);
            yb = (xb == xa) ? $urandom_range(0, MAX_POS) : ya;
        end else if (kind < 96) begin
            d  = $urandom_range(0, MAX_POS);
            xb = clip($urandom_range(0, 1) ? xa + d : xa - d);
            d  = (xb > xa) ? xb - xa : xa - xb;
            yb = (ya + d <= MAX_POS) ? ya + d : ya - d;
        end else begin
            xb = xa;
            yb = ya;
        end
        return segment(xa, ya, random_depth(), random_color(),
                       xb, yb, random_depth(), random_color());
    endfunction

    // offer one segment, optionally after an idle burst; returns at a falling edge
    task automatic send_segment(input logic [S_W-1:0] seg, input bit gaps);
        if (gaps && $urandom_range(0, 2) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(negedge aclk);
        end
        s_tdata  <= seg;
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        segs_sent++;
        rx_idling = gaps;
        @(negedge aclk);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        wait (pixels_pending == 0);
        @(negedge aclk);
    endtask

    // result side: random stall bursts and one long hold-off
    initial begin
        int stall_left;
        bit hold_done;
        stall_left = 0;
        hold_done  = 1'b0;
        m_tready   = 1'b0;
        forever begin
            @(negedge aclk);
            if (!hold_done && segs_sent >= HOLD_AT) begin
                hold_done = 1'b1;
                m_tready <= 1'b0;
                for (int n = 0; n < HOLD_CYCLES; n++)
                    @(negedge aclk);
            end else if (stall_left > 0) begin
                m_tready <= 1'b0;
                stall_left--;
            end else if (rx_idling && $urandom_range(0, 5) == 0) begin
                m_tready <= 1'b0;
                stall_left = $urandom_range(1, 11) - 1;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // stimulus and verdict
    initial begin
        bit gaps;
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed corners
        send_segment(segment(0, 0, 16'h0000, 32'h00000000, 0, 0, 16'h0000, 32'h00000000), 1'b1);
        send_segment(segment(63, 63, 16'hFFFF, 32'hFFFFFFFF, 63, 63, 16'h0000, 32'h00000000), 1'b1);
        send_segment(segment(0, 0, 16'h0000, 32'h00000000, 63, 0, 16'hFFFF, 32'hFFFFFFFF), 1'b1);
        send_segment(segment(63, 0, 16'hFFFF, 32'hFFFFFFFF, 0, 0, 16'h0000, 32'h00000000), 1'b1);
        send_segment(segment(0, 0, 16'h0000, 32'hFF00FF00, 0, 63, 16'hFFFF, 32'h00FF00FF), 1'b1);
        send_segment(segment(0, 63, 16'h1234, 32'h00FF00FF, 0, 0, 16'hFEDC, 32'hFF00FF00), 1'b1);
        send_segment(segment(0, 0, 16'hFFFF, 32'h80808080, 63, 63, 16'h0000, 32'h7F7F7F7F), 1'b1);
        send_segment(segment(63, 0, 16'h0001, 32'h01020304, 0, 63, 16'hFFFE, 32'hFCFDFEFF), 1'b1);
        send_segment(segment(0, 40, 16'h8000, 32'hA5A5A5A5, 63, 20, 16'h7FFF, 32'h5A5A5A5A), 1'b1);
        send_segment(segment(50, 0, 16'h0100, 32'h10203040, 10, 63, 16'h0FF0, 32'hF0E0D0C0), 1'b1);
        send_segment(segment(5, 5, 16'h0000, 32'h00000000, 6, 5, 16'h0001, 32'h01010101), 1'b1);
        send_segment(segment(5, 5, 16'h0001, 32'h01010101, 5, 6, 16'h0000, 32'h00000000), 1'b1);
        send_segment(segment(0, 0, 16'h0000, 32'h00000000, 3, 0, 16'h0001, 32'h01020301), 1'b1);
        send_segment(segment(0, 0, 16'h000A, 32'h0A0B0C0D, 3, 1, 16'h0000, 32'h00000000), 1'b1);
        send_segment(segment(10, 10, 16'hFFFF, 32'hFF000000, 12, 11, 16'hFFFD, 32'h00FF0000), 1'b1);
        send_segment(segment(20, 30, 16'h0007, 32'h0000FF00, 21, 33, 16'h0000, 32'h000000FF), 1'b1);
        send_segment(segment(63, 63, 16'h4000, 32'h33333333, 0, 62, 16'hC000, 32'hCCCCCCCC), 1'b1);
        send_segment(segment(1, 62, 16'hAAAA, 32'hDEADBEEF, 62, 1, 16'h5555, 32'h12345678), 1'b1);
        send_segment(segment(32, 0, 16'h0000, 32'hFFFFFFFF, 33, 63, 16'hFFFF, 32'h00000000), 1'b1);
        send_segment(segment(0, 31, 16'hFFFF, 32'h00000000, 63, 32, 16'h0000, 32'hFFFFFFFF), 1'b1);
        wait_drained();

        // random segments, idling in phases, none in the tail
        for (int i = 0; i < RANDOM_SEGS; i++) begin
            gaps = (i < RANDOM_SEGS - QUIET_TAIL) && ((i / 40) % 3 != 2);
            if (i == 150 || i == 280)
                wait_drained();
            send_segment(random_segment(), gaps);
        end
        s_tvalid <= 1'b0;

        wait (pixels_pending == 0);
        repeat (300) @(posedge aclk);
        if (mismatches == 0 && pixels_pending == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // watchdog
    initial begin
        #4000000;
        $display("status: fail");
        $finish;
    end

endmodule

`default_nettype wire
